/* src/ground_plane_texture_coordinates_assert.svh */
// Assertion macros for the ground plane texture coordinate block
`ifndef GROUND_PLANE_TEXTURE_COORDINATES_ASSERT_SVH
`define GROUND_PLANE_TEXTURE_COORDINATES_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define GPTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gptc assertion failed");

// Next-cycle implication, disabled during reset
`define GPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gptc assertion failed");

`endif

/* src/gptc_pkg.sv */
// Shared constants, types and the sine table for the ground plane texture coordinate block
package gptc_pkg;

    localparam int SINE_DEPTH   = 1024;
    localparam int FRAC_BITS    = 16;
    localparam int SINE_IDX_W   = $clog2(SINE_DEPTH);
    localparam int SINE_W       = FRAC_BITS + 2;
    localparam int PROD_W       = SINE_W + 32;
    localparam int NUM_CORNERS  = 8;
    localparam int STEP_W       = 5;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = 2;
    localparam int QUEUE_CNT_W  = 3;

    localparam int DIV_W        = 56;
    localparam int DIV_NUM_W    = DIV_W + 1;
    localparam int DEN_W        = 11;
    localparam int ROW_NUM_W    = 44;
    localparam int DX_W         = 47;

    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 64;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 3;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;

    // Taylor term divisors (2k)(2k+1) for k = 1..7
    localparam longint unsigned TAYLOR_DIV [8] = '{64'd1, 64'd6, 64'd20, 64'd42,
                                                    64'd72, 64'd110, 64'd156, 64'd210};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEWER_X     = 3'd0,
        REG_VIEWER_Y     = 3'd1,
        REG_HEADING      = 3'd2,
        REG_NEAR         = 3'd3,
        REG_FAR          = 3'd4,
        REG_HALF_FOV     = 3'd5,
        REG_COL_COUNT    = 3'd6,
        REG_HALF_HEIGHT  = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [NUM_CORNERS-1:0][31:0] corners;
        logic [9:0]                   half_height;
        logic [10:0]                  col_count;
    } geom_t;

    typedef struct packed {
        logic [9:0] column;
        logic [8:0] row;
        logic       in_range;
        logic [9:0] ground_row;
        logic [9:0] sky_row;
    } item_t;

    typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_DEPTH];

    // Quarter-wave sine by Taylor series in Q30 radians, rounded to Q1.FRAC_BITS
    function automatic logic signed [SINE_W-1:0] quarter_sine(longint a);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        int              k;
        x    = longint'(a);
        x2   = (x * x) >> 30;
        term = x;
        sum  = a;
        for (k = 1; k <= 7; k++)
        begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k[2:0]];
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (longint'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (v > (64'd1 << FRAC_BITS))
            v = 64'd1 << FRAC_BITS;
        return SINE_W'(v);
    endfunction

    // Full-wave table built from the quarter wave
    function automatic sine_tab_t build_sine();
        sine_tab_t t;
        longint    x;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            x = (longint'(i) * TWO_PI_Q30) >>> SINE_IDX_W;
            if (x <= HALF_PI_Q30)
                t[i] = quarter_sine(x);
            else if (x <= PI_Q30)
                t[i] = quarter_sine(PI_Q30 - x);
            else if (x <= PI_Q30 + HALF_PI_Q30)
                t[i] = -quarter_sine(x - PI_Q30);
            else
                t[i] = -quarter_sine((TWO_PI_Q30 - x > 0) ? TWO_PI_Q30 - x : 64'sd0);
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

endpackage

/* src/gptc_cfg.sv */
// Configuration registers and frustum corner sequencer
module gptc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gptc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gptc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output gptc_pkg::geom_t                     geom,
    output logic                                busy
);

    logic signed [31:0] viewer_x_reg;
    logic signed [31:0] viewer_y_reg;
    logic [15:0]        heading_reg;
    logic [30:0]        near_reg;
    logic [30:0]        far_reg;
    logic [14:0]        half_fov_reg;
    logic [10:0]        col_count_reg;
    logic [9:0]         half_height_reg;
    logic               busy_reg;
    logic [gptc_pkg::STEP_W-1:0] step_reg;

    logic [2:0]         corner_idx;
    logic [1:0]         phase;
    logic [15:0]        side_angle;
    logic [15:0]        angle;
    logic [31:0]        idx_wide;
    logic [gptc_pkg::SINE_IDX_W-1:0] rom_idx;
    logic [30:0]        plane_dist;
    logic signed [31:0] base;
    logic signed [gptc_pkg::SINE_W-1:0] trig_reg;
    logic signed [gptc_pkg::PROD_W-1:0] prod_reg;
    logic signed [gptc_pkg::PROD_W-1:0] prod_shift;
    logic [31:0]        corner_new;
    logic [gptc_pkg::NUM_CORNERS-1:0][31:0] corners_reg;

    // Registers and sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            viewer_x_reg     <= 32'sd65536000;
            viewer_y_reg     <= 32'sd65536000;
            heading_reg      <= 16'd0;
            near_reg         <= 31'd655;
            far_reg          <= 31'd6554;
            half_fov_reg     <= 15'd8192;
            col_count_reg    <= 11'd320;
            half_height_reg  <= 10'd120;
            busy_reg         <= 1'b1;
            step_reg         <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gptc_pkg::REG_VIEWER_X:     viewer_x_reg     <= cfg_data;
                gptc_pkg::REG_VIEWER_Y:     viewer_y_reg     <= cfg_data;
                gptc_pkg::REG_HEADING:      heading_reg      <= cfg_data[15:0];
                gptc_pkg::REG_NEAR:         near_reg         <= cfg_data[30:0];
                gptc_pkg::REG_FAR:          far_reg          <= cfg_data[30:0];
                gptc_pkg::REG_HALF_FOV:     half_fov_reg     <= cfg_data[14:0];
                gptc_pkg::REG_COL_COUNT:    col_count_reg    <= cfg_data[10:0];
                gptc_pkg::REG_HALF_HEIGHT:  half_height_reg  <= cfg_data[9:0];
                default:                    ;
            endcase
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == '1)
                busy_reg <= 1'b0;
        end
    end

    // Even corners are x (cosine), odd are y (sine); bit 1 picks the side, bit 2 near
    assign corner_idx = step_reg[4:2];
    assign phase      = step_reg[1:0];
    assign side_angle = corner_idx[1] ? heading_reg + {1'b0, half_fov_reg}
                                      : heading_reg - {1'b0, half_fov_reg};
    assign angle      = corner_idx[0] ? side_angle : side_angle + 16'd16384;
    assign idx_wide   = ({16'd0, angle} * 32'(gptc_pkg::SINE_DEPTH)) >> 16;
    assign rom_idx    = idx_wide[gptc_pkg::SINE_IDX_W-1:0];
    assign plane_dist = corner_idx[2] ? near_reg : far_reg;
    assign base       = corner_idx[0] ? viewer_y_reg : viewer_x_reg;

    // Sine lookup, product, then scale and add
    always_ff @(posedge clk)
    begin
        trig_reg <= gptc_pkg::SINE_TAB[rom_idx];
        prod_reg <= trig_reg * $signed({1'b0, plane_dist});
    end

    assign prod_shift = prod_reg >>> gptc_pkg::FRAC_BITS;
    assign corner_new = base + prod_shift[31:0];

    // Write the corner once its product has settled
    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_we && phase == 2'd3)
            corners_reg[corner_idx] <= corner_new;
    end

    assign geom.corners      = corners_reg;
    assign geom.half_height  = half_height_reg;
    assign geom.col_count    = col_count_reg;
    assign busy              = busy_reg;

endmodule

/* src/gptc_front.sv */
// Input side: accept pixel beats and classify them for the queue
module gptc_front (
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [gptc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              busy,
    input  logic                              full,
    input  logic [9:0]                        half_height,
    output logic                              push,
    output gptc_pkg::item_t                   push_item
);

    logic [9:0] row_ext;

    // Hold off while corners rebuild or the queue is full
    assign s_axis_tready = !full && !busy;
    assign push          = s_axis_tvalid && s_axis_tready;

    // Classify: row zero has no depth; screen rows wrap to ten bits
    assign row_ext              = {1'b0, s_axis_tdata[18:10]};
    assign push_item.column     = s_axis_tdata[9:0];
    assign push_item.row        = s_axis_tdata[18:10];
    assign push_item.in_range   = (s_axis_tdata[18:10] != 9'd0);
    assign push_item.ground_row = row_ext + half_height;
    assign push_item.sky_row    = half_height - row_ext;

endmodule

/* src/gptc_queue.sv */
// Short queue between the front and back parts
module gptc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gptc_pkg::item_t push_item,
    input  logic            pop,
    output gptc_pkg::item_t pop_item,
    output logic            full,
    output logic            empty
);

    gptc_pkg::item_t                  entry_reg [gptc_pkg::QUEUE_DEPTH];
    logic [gptc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [gptc_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [gptc_pkg::QUEUE_CNT_W-1:0] count_reg;

    assign full     = (count_reg == gptc_pkg::QUEUE_CNT_W'(gptc_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* src/gptc_div.sv */
// Pipelined signed floor divider, one quotient bit per stage
module gptc_div (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic signed [gptc_pkg::DIV_NUM_W-1:0]    in_num,
    input  logic [gptc_pkg::DEN_W-1:0]               in_den,
    output logic signed [gptc_pkg::DIV_NUM_W-1:0]    quo
);

    localparam int W  = gptc_pkg::DIV_W;
    localparam int DW = gptc_pkg::DEN_W;
    localparam int NW = gptc_pkg::DIV_NUM_W;

    logic [DW:0]   rem_reg [W];
    logic [W-1:0]  wrd_reg [W];
    logic [DW-1:0] den_reg [W];
    logic [W-1:0]  neg_reg;

    logic [DW:0]   rem_in  [W];
    logic [W-1:0]  wrd_in  [W];
    logic [DW-1:0] den_in  [W];
    logic [W-1:0]  neg_in;
    logic [DW:0]   trial   [W];
    logic [W-1:0]  fits;
    logic [NW-1:0] mag_in;
    logic [NW-1:0] mag_q;
    logic          rem_nz;

    assign mag_in = in_num[NW-1] ? -in_num : in_num;

    // Chain stage inputs and trial subtractions
    always_comb
    begin
        rem_in[0] = '0;
        wrd_in[0] = mag_in[W-1:0];
        den_in[0] = in_den;
        neg_in[0] = in_num[NW-1];
        for (int s = 1; s < W; s++)
        begin
            rem_in[s] = rem_reg[s-1];
            wrd_in[s] = wrd_reg[s-1];
            den_in[s] = den_reg[s-1];
            neg_in[s] = neg_reg[s-1];
        end
        for (int s = 0; s < W; s++)
        begin
            trial[s] = {rem_in[s][DW-1:0], wrd_in[s][W-1]};
            fits[s]  = (trial[s] >= {1'b0, den_in[s]});
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < W; s++)
            begin
                rem_reg[s] <= fits[s] ? trial[s] - {1'b0, den_in[s]} : trial[s];
                wrd_reg[s] <= {wrd_in[s][W-2:0], fits[s]};
                den_reg[s] <= den_in[s];
                neg_reg[s] <= neg_in[s];
            end
        end
    end

    // Round toward minus infinity for negative dividends
    assign mag_q  = {1'b0, wrd_reg[W-1]};
    assign rem_nz = (rem_reg[W-1] != '0);
    assign quo    = neg_reg[W-1] ? $signed(-mag_q - {{(NW-1){1'b0}}, rem_nz})
                                 : $signed(mag_q);

endmodule

/* src/gptc_back.sv */
// Back part: row projection, column interpolation and output register
module gptc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gptc_pkg::geom_t                    geom,
    input  gptc_pkg::item_t                    pop_item,
    input  logic                               empty,
    output logic                               pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gptc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tuser
);

    localparam int W  = gptc_pkg::DIV_W;
    localparam int NW = gptc_pkg::DIV_NUM_W;
    localparam int RW = gptc_pkg::ROW_NUM_W;
    localparam int XW = gptc_pkg::DX_W;

    logic en;

    // Stage A
    logic signed [32:0]            diff [4];
    logic signed [RW-1:0]          num_next [4];
    logic                          a_vld_reg;
    gptc_pkg::item_t               a_item_reg;
    logic signed [RW-1:0]          a_num_reg [4];
    logic [3:0][31:0]              a_near_reg;
    logic [gptc_pkg::DEN_W-1:0]    a_den_reg;
    logic signed [NW-1:0]          q1 [4];

    // First delay line
    logic [W-1:0]                  dl1_vld_reg;
    gptc_pkg::item_t               dl1_item_reg [W];
    logic [3:0][31:0]              dl1_near_reg [W];

    // Stages B and C
    logic signed [NW-1:0]          pt [4];
    logic signed [NW-1:0]          dx_full;
    logic signed [NW-1:0]          dy_full;
    logic                          b_vld_reg;
    gptc_pkg::item_t               b_item_reg;
    logic signed [XW-1:0]          b_dx_reg;
    logic signed [XW-1:0]          b_dy_reg;
    logic [15:0]                   b_sx_reg;
    logic [15:0]                   b_sy_reg;
    logic [gptc_pkg::DEN_W-1:0]    b_den_reg;
    logic signed [XW+10:0]         px_prod;
    logic signed [XW+10:0]         py_prod;
    logic                          c_vld_reg;
    gptc_pkg::item_t               c_item_reg;
    logic signed [NW-1:0]          c_px_reg;
    logic signed [NW-1:0]          c_py_reg;
    logic [15:0]                   c_sx_reg;
    logic [15:0]                   c_sy_reg;
    logic [gptc_pkg::DEN_W-1:0]    c_den_reg;
    logic signed [NW-1:0]          qx;
    logic signed [NW-1:0]          qy;

    // Second delay line
    logic [W-1:0]                  dl2_vld_reg;
    gptc_pkg::item_t               dl2_item_reg [W];
    logic [15:0]                   dl2_sx_reg [W];
    logic [15:0]                   dl2_sy_reg [W];

    // Output register
    logic                          out_vld_reg;
    logic [gptc_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                          out_user_reg;
    logic [15:0]                   tex_u;
    logic [15:0]                   tex_v;
    gptc_pkg::item_t               last_item;

    // The whole pipeline advances when the output register can take a beat
    assign en  = !out_vld_reg || m_axis_tready;
    assign pop = en && !empty;

    // Depth span per corner pair: (far - near) * half_height
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            diff[k]     = $signed({geom.corners[k][31], geom.corners[k]})
                        - $signed({geom.corners[k+4][31], geom.corners[k+4]});
            num_next[k] = diff[k] * $signed({1'b0, geom.half_height});
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            dl1_vld_reg <= '0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            dl2_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg   <= pop;
            dl1_vld_reg <= {dl1_vld_reg[W-2:0], a_vld_reg};
            b_vld_reg   <= dl1_vld_reg[W-1];
            c_vld_reg   <= b_vld_reg;
            dl2_vld_reg <= {dl2_vld_reg[W-2:0], c_vld_reg};
            out_vld_reg <= dl2_vld_reg[W-1];
        end
    end

    // Stage A: span products, near points, row divisor (row zero divides by one)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= pop_item;
            for (int k = 0; k < 4; k++)
            begin
                a_num_reg[k]  <= num_next[k];
                a_near_reg[k] <= geom.corners[k+4];
            end
            a_den_reg <= (pop_item.row == 9'd0) ? gptc_pkg::DEN_W'(1)
                                                : {2'b00, pop_item.row};
        end
    end

    // Row dividers
    for (genvar k = 0; k < 4; k++)
    begin : g_row_div
        gptc_div u_div (
            .clk    (clk),
            .en     (en),
            .in_num ({{(NW-RW){a_num_reg[k][RW-1]}}, a_num_reg[k]}),
            .in_den (a_den_reg),
            .quo    (q1[k])
        );
    end

    // Carry item and near points alongside the row dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl1_item_reg[0] <= a_item_reg;
            dl1_near_reg[0] <= a_near_reg;
            for (int i = 1; i < W; i++)
            begin
                dl1_item_reg[i] <= dl1_item_reg[i-1];
                dl1_near_reg[i] <= dl1_near_reg[i-1];
            end
        end
    end

    // Stage B: row start and end, then span across the row
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            pt[k] = q1[k] + $signed({{(NW-32){dl1_near_reg[W-1][k][31]}},
                                     dl1_near_reg[W-1][k]});
        end
        dx_full = pt[2] - pt[0];
        dy_full = pt[3] - pt[1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_item_reg <= dl1_item_reg[W-1];
            b_dx_reg   <= dx_full[XW-1:0];
            b_dy_reg   <= dy_full[XW-1:0];
            b_sx_reg   <= pt[0][15:0];
            b_sy_reg   <= pt[1][15:0];
            b_den_reg  <= (geom.col_count == '0) ? gptc_pkg::DEN_W'(1)
                                                 : geom.col_count;
        end
    end

    // Stage C: span times column
    assign px_prod = b_dx_reg * $signed({1'b0, b_item_reg.column});
    assign py_prod = b_dy_reg * $signed({1'b0, b_item_reg.column});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_item_reg <= b_item_reg;
            c_px_reg   <= px_prod[NW-1:0];
            c_py_reg   <= py_prod[NW-1:0];
            c_sx_reg   <= b_sx_reg;
            c_sy_reg   <= b_sy_reg;
            c_den_reg  <= b_den_reg;
        end
    end

    // Column dividers
    gptc_div u_div_x (
        .clk    (clk),
        .en     (en),
        .in_num (c_px_reg),
        .in_den (c_den_reg),
        .quo    (qx)
    );

    gptc_div u_div_y (
        .clk    (clk),
        .en     (en),
        .in_num (c_py_reg),
        .in_den (c_den_reg),
        .quo    (qy)
    );

    // Carry item and start fractions alongside the column dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl2_item_reg[0] <= c_item_reg;
            dl2_sx_reg[0]   <= c_sx_reg;
            dl2_sy_reg[0]   <= c_sy_reg;
            for (int i = 1; i < W; i++)
            begin
                dl2_item_reg[i] <= dl2_item_reg[i-1];
                dl2_sx_reg[i]   <= dl2_sx_reg[i-1];
                dl2_sy_reg[i]   <= dl2_sy_reg[i-1];
            end
        end
    end

    // Keep only the fraction; row zero gives zero coordinates
    assign last_item = dl2_item_reg[W-1];
    assign tex_u     = last_item.in_range ? qx[15:0] + dl2_sx_reg[W-1] : 16'd0;
    assign tex_v     = last_item.in_range ? qy[15:0] + dl2_sy_reg[W-1] : 16'd0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {2'b00, last_item.sky_row, last_item.ground_row,
                             last_item.column, tex_v, tex_u};
            out_user_reg <= last_item.in_range;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

/* src/ground_plane_texture_coordinates.sv */
// Top level of the ground plane texture coordinate block
//
// Usage: each input beat on s_axis carries one screen pixel (column, row within the
// half screen); each output beat on m_axis carries its wrapped texture coordinates
// on a perspective ground plane, plus the pixel's column, ground row and sky row.
// m_axis_tuser is high for a valid pixel and low for row zero (coordinates zero).
// Throughput is one pixel per clock unless a rebuild or back-pressure stalls it. An
// accepted input beat passes through the queue, two banks of 56-stage pipelined
// dividers (row scaling, then column interpolation), three product stages and the
// output register. Configuration writes on cfg_we/cfg_index/cfg_data are taken any
// cycle. After reset and after every write the corner sequencer rebuilds the eight
// frustum corners, one at a time through the sine table; s_axis_tready stays
// low meanwhile. When the receiver holds m_axis_tready low, the whole back pipeline
// holds, the four-entry queue fills, and s_axis_tready then drops.
`include "ground_plane_texture_coordinates_assert.svh"

module ground_plane_texture_coordinates (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [gptc_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // column[9:0], row[18:10]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tex_u[15:0], tex_v[31:16], out_column[41:32], ground_row[51:42], sky_row[61:52]
    output logic [gptc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,   // in_range[0]
    input  logic                                cfg_we,
    input  logic [gptc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gptc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gptc_pkg::geom_t geom;
    gptc_pkg::item_t push_item;
    gptc_pkg::item_t pop_item;
    logic            busy;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    // Registers and corner rebuild
    gptc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .busy      (busy)
    );

    // Accept and classify beats
    gptc_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .busy          (busy),
        .full          (full),
        .half_height   (geom.half_height),
        .push          (push),
        .push_item     (push_item)
    );

    // Decouple front and back
    gptc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (full),
        .empty     (empty)
    );

    // Project and interpolate
    gptc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .geom          (geom),
        .pop_item      (pop_item),
        .empty         (empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // No beat is taken while corners are being rebuilt
    `GPTC_ASSERT_NOW(a_no_accept_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !busy)
    // A register write starts a rebuild, so input stalls next cycle
    `GPTC_ASSERT_NEXT(a_write_stalls, clk, rst_n, cfg_we, !s_axis_tready)
    // Row zero results carry zero coordinates
    `GPTC_ASSERT_NOW(a_row_zero_coords, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
                     m_axis_tdata[31:0] == 32'd0)

endmodule

/* verif/ground_plane_texture_coordinates_tb.sv */
// Self-checking testbench for the ground plane texture coordinate block
`timescale 1ns / 100ps

module ground_plane_texture_coordinates_tb;

    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam int     CYCLE_LIMIT = 600000;
    localparam int     DRAIN_WAIT  = 160;

    typedef struct {
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic [9:0]  out_column;
        logic [9:0]  ground_row;
        logic [9:0]  sky_row;
        logic        in_range;
    } texel_t;

    typedef struct {
        logic [9:0] column;
        logic [8:0] row;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [gptc_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [gptc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_we = 1'b0;
    logic [gptc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gptc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: its own copy of the registers, sine table and corners
    int          sin_lut [1024];
    logic [31:0] view_x, view_y;
    logic [15:0] view_heading;
    logic [30:0] dist_near, dist_far;
    logic [14:0] fov_half;
    logic [10:0] scr_width;
    logic [9:0]  scr_half_h;
    logic [31:0] corner_q [8];

    pixel_t pixel_q [$];
    texel_t texel_q [$];
    int     mismatches = 0;
    int     texels_seen = 0;
    int     invalid_seen = 0;
    int     cycles = 0;
    bit     calm = 1'b0;
    bit     in_took = 1'b0;
    int     in_gap = 0;
    int     out_gap = 0;

    ground_plane_texture_coordinates u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Floor division on signed 64-bit values
    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // Sine over a quarter turn, Q30 radians in, Q1.16 magnitude out
    function automatic int taylor_sine(longint a);
        longint unsigned x, x2, term, v;
        longint          acc;
        x = a;
        x2 = (x * x) >> 30;
        term = x;
        acc = a;
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        v = (longint'(acc) + 64'd8192) >> 14;
        if (v > 64'd65536)
            v = 64'd65536;
        return int'(v);
    endfunction

    task automatic fill_sine_lut();
        longint x;
        for (int i = 0; i < 1024; i++)
        begin
            x = (longint'(i) * Q30_TWO_PI) / 1024;
            if (x <= Q30_HALF_PI)
                sin_lut[i] = taylor_sine(x);
            else if (x <= Q30_PI)
                sin_lut[i] = taylor_sine(Q30_PI - x);
            else if (x <= Q30_PI + Q30_HALF_PI)
                sin_lut[i] = -taylor_sine(x - Q30_PI);
            else
                sin_lut[i] = -taylor_sine((Q30_TWO_PI - x > 0) ? Q30_TWO_PI - x : 0);
        end
    endtask

    function automatic longint sine_at(logic [15:0] ang);
        return longint'(sin_lut[ang >> 6]);
    endfunction

    function automatic logic [31:0] corner_at(logic [31:0] base, longint trig,
                                              logic [30:0] plane_dist);
        longint p;
        p = floor_quot(trig * longint'({1'b0, plane_dist}), 64'sd65536);
        return 32'(longint'(signed'(base)) + p);
    endfunction

    // Rebuild the eight frustum corners from the current registers
    task automatic refresh_corners();
        logic [15:0] a1, a2;
        a1 = view_heading - {1'b0, fov_half};
        a2 = view_heading + {1'b0, fov_half};
        corner_q[0] = corner_at(view_x, sine_at(a1 + 16'd16384), dist_far);
        corner_q[1] = corner_at(view_y, sine_at(a1), dist_far);
        corner_q[2] = corner_at(view_x, sine_at(a2 + 16'd16384), dist_far);
        corner_q[3] = corner_at(view_y, sine_at(a2), dist_far);
        corner_q[4] = corner_at(view_x, sine_at(a1 + 16'd16384), dist_near);
        corner_q[5] = corner_at(view_y, sine_at(a1), dist_near);
        corner_q[6] = corner_at(view_x, sine_at(a2 + 16'd16384), dist_near);
        corner_q[7] = corner_at(view_y, sine_at(a2), dist_near);
    endtask

    function automatic longint edge_point(int fi, int ni, logic [8:0] row);
        longint f, n;
        f = longint'(signed'(corner_q[fi]));
        n = longint'(signed'(corner_q[ni]));
        return floor_quot((f - n) * longint'({1'b0, scr_half_h}), longint'({1'b0, row})) + n;
    endfunction

    // Expected texel for one pixel under the current geometry
    function automatic texel_t predict_texel(logic [9:0] column, logic [8:0] row);
        texel_t t;
        longint w, sx, sy, ex, ey, px, py;
        t.tex_u = '0;
        t.tex_v = '0;
        t.in_range = 1'b0;
        if (row != 0)
        begin
            w = (scr_width != 0) ? longint'({1'b0, scr_width}) : 64'sd1;
            sx = edge_point(0, 4, row);
            sy = edge_point(1, 5, row);
            ex = edge_point(2, 6, row);
            ey = edge_point(3, 7, row);
            px = floor_quot((ex - sx) * longint'({1'b0, column}), w) + sx;
            py = floor_quot((ey - sy) * longint'({1'b0, column}), w) + sy;
            t.tex_u = px[15:0];
            t.tex_v = py[15:0];
            t.in_range = 1'b1;
        end
        t.out_column = column;
        t.ground_row = 10'({1'b0, row} + scr_half_h);
        t.sky_row = 10'(scr_half_h - {1'b0, row});
        return t;
    endfunction

    task automatic report(string what, longint got, longint want);
        mismatches++;
        $display("[%0t] %s: got %0h expected %0h", $time, what, got, want);
    endtask

    // Drive one register write and mirror it in the predictor
    task automatic write_reg(gptc_pkg::cfg_reg_e idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            gptc_pkg::REG_VIEWER_X:     view_x = val;
            gptc_pkg::REG_VIEWER_Y:     view_y = val;
            gptc_pkg::REG_HEADING:      view_heading = val[15:0];
            gptc_pkg::REG_NEAR:         dist_near = val[30:0];
            gptc_pkg::REG_FAR:          dist_far = val[30:0];
            gptc_pkg::REG_HALF_FOV:     fov_half = val[14:0];
            gptc_pkg::REG_COL_COUNT:    scr_width = val[10:0];
            default:                    scr_half_h = val[9:0];
        endcase
        refresh_corners();
    endtask

    task automatic set_geometry(logic [31:0] vx, logic [31:0] vy, logic [31:0] hd,
                                logic [31:0] nr, logic [31:0] fr, logic [31:0] fov,
                                logic [31:0] wd, logic [31:0] hh);
        write_reg(gptc_pkg::REG_VIEWER_X, vx);
        write_reg(gptc_pkg::REG_VIEWER_Y, vy);
        write_reg(gptc_pkg::REG_HEADING, hd);
        write_reg(gptc_pkg::REG_NEAR, nr);
        write_reg(gptc_pkg::REG_FAR, fr);
        write_reg(gptc_pkg::REG_HALF_FOV, fov);
        write_reg(gptc_pkg::REG_COL_COUNT, wd);
        write_reg(gptc_pkg::REG_HALF_HEIGHT, hh);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_pixel(int column, int row);
        pixel_t p;
        p.column = column[9:0];
        p.row = row[8:0];
        pixel_q.push_back(p);
    endtask

    // Hold until every pixel has gone in and every texel has come back
    task automatic wait_drained();
        wait (pixel_q.size() == 0 && !s_axis_tvalid && texel_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Corner pixels of the field plus row zero and out-of-screen cases
    task automatic queue_directed();
        queue_pixel(0, 0);
        queue_pixel(1023, 0);
        queue_pixel(0, 1);
        queue_pixel(1023, 1);
        queue_pixel(0, 511);
        queue_pixel(1023, 511);
        queue_pixel(319, 119);
        queue_pixel(160, 60);
        queue_pixel(1, 2);
        queue_pixel(512, 256);
        queue_pixel(341, 170);
        queue_pixel(682, 341);
        queue_pixel(600, 300);
    endtask

    // Random pixels, mostly on screen, some anywhere in the field range
    task automatic queue_random(int count);
        int wmax, hmax;
        wmax = (scr_width == 0) ? 1023 : ((scr_width > 1024) ? 1023 : scr_width - 1);
        hmax = (scr_half_h == 0) ? 511 : ((scr_half_h > 512) ? 511 : scr_half_h - 1);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_pixel($urandom_range(0, 1023), $urandom_range(0, 511));
            else
                queue_pixel($urandom_range(0, wmax), $urandom_range(0, hmax));
        end
    endtask

    // Pixel driver: advance on acceptance, insert random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_took))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pixel_q.size() != 0 && !calm && $urandom_range(0, 9) == 0)
            begin
                in_gap = $urandom_range(0, 14);
                s_axis_tvalid <= 1'b0;
            end
            else if (pixel_q.size() != 0)
            begin
                pixel_t p;
                p = pixel_q.pop_front();
                s_axis_tdata <= {5'b0, p.row, p.column};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stall bursts on m_axis_tready
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_gap = $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted pixel, check each texel beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_took = s_axis_tvalid && s_axis_tready;
            if (in_took)
                texel_q.push_back(predict_texel(s_axis_tdata[9:0], s_axis_tdata[18:10]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                texels_seen++;
                if (!m_axis_tuser)
                    invalid_seen++;
                if (texel_q.size() == 0)
                    report("texel with no pixel pending", m_axis_tdata, 0);
                else
                begin
                    texel_t e;
                    e = texel_q.pop_front();
                    if (m_axis_tdata[15:0] !== e.tex_u)
                        report("tex_u", m_axis_tdata[15:0], e.tex_u);
                    if (m_axis_tdata[31:16] !== e.tex_v)
                        report("tex_v", m_axis_tdata[31:16], e.tex_v);
                    if (m_axis_tdata[41:32] !== e.out_column)
                        report("out_column", m_axis_tdata[41:32], e.out_column);
                    if (m_axis_tdata[51:42] !== e.ground_row)
                        report("ground_row", m_axis_tdata[51:42], e.ground_row);
                    if (m_axis_tdata[61:52] !== e.sky_row)
                        report("sky_row", m_axis_tdata[61:52], e.sky_row);
                    if (m_axis_tuser !== e.in_range)
                        report("in_range", m_axis_tuser, e.in_range);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        view_x = 32'd65536000;
        view_y = 32'd65536000;
        view_heading = 16'd0;
        dist_near = 31'd655;
        dist_far = 31'd6554;
        fov_half = 15'd8192;
        scr_width = 11'd320;
        scr_half_h = 10'd120;
        fill_sine_lut();
        refresh_corners();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry, directed pixels
        queue_directed();
        wait_drained();

        // Extreme geometry: zero width and height, max far, wrapping corners
        set_geometry(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF, 32'h0, 32'h7FFF_FFFF,
                     32'h7FFF, 32'h0, 32'h0);
        queue_directed();
        queue_random(40);
        wait_drained();

        set_geometry(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0,
                     32'h7FF, 32'h3FF);
        queue_random(60);
        wait_drained();

        // Random geometries, the last without idling
        for (int ph = 0; ph < 10; ph++)
        begin
            set_geometry($urandom, $urandom, $urandom_range(0, 65535),
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20),
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 22),
                         ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32767)
                                                     : $urandom_range(0, 16384),
                         $urandom_range(1, 1024), $urandom_range(1, 512));
            calm = (ph == 9);
            queue_random(95);
            wait_drained();
        end

        if (texel_q.size() != 0)
            report("texels never returned", texel_q.size(), 0);
        $display("Covered %0d texels (%0d at row zero) over 13 geometries,",
                 texels_seen, invalid_seen);
        $display("including zero width and height and wrapping corners.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/gptc_pkg.sv
src/gptc_cfg.sv
src/gptc_front.sv
src/gptc_queue.sv
src/gptc_div.sv
src/gptc_back.sv
src/ground_plane_texture_coordinates.sv
verif/ground_plane_texture_coordinates_tb.sv
